// ===== rtl/rv64dec_pkg.sv =====
// ----------------------------------------------------------------------------
// rv64dec_pkg
// Operation numbers, operand kinds and major opcodes for the RV64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package rv64dec_pkg;

  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_INT  = 3'd1,
    K_FP   = 3'd2,
    K_IMM  = 3'd3,
    K_CSR  = 3'd4
  } kind_t;

  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1b;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_STORE_FP = 7'h27;
  localparam logic [6:0] OPC_AMO      = 7'h2f;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_OP32     = 7'h3b;
  localparam logic [6:0] OPC_FMADD    = 7'h43;
  localparam logic [6:0] OPC_FMSUB    = 7'h47;
  localparam logic [6:0] OPC_FNMSUB   = 7'h4b;
  localparam logic [6:0] OPC_FNMADD   = 7'h4f;
  localparam logic [6:0] OPC_OP_FP    = 7'h53;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6f;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  localparam logic [31:0] W_FENCE_I = 32'h0000100f;
  localparam logic [31:0] W_ECALL   = 32'h00000073;
  localparam logic [31:0] W_EBREAK  = 32'h00100073;
  localparam logic [31:0] W_SRET    = 32'h10200073;
  localparam logic [31:0] W_WFI     = 32'h10500073;
  localparam logic [31:0] W_MRET    = 32'h30200073;

  localparam logic [7:0] OP_INVALID  = 8'd0;
  localparam logic [7:0] OP_LB       = 8'd1;
  localparam logic [7:0] OP_FLW      = 8'd8;
  localparam logic [7:0] OP_FENCE    = 8'd10;
  localparam logic [7:0] OP_FENCE_I  = 8'd11;
  localparam logic [7:0] OP_ADD      = 8'd12;
  localparam logic [7:0] OP_SUB      = 8'd13;
  localparam logic [7:0] OP_SLL      = 8'd14;
  localparam logic [7:0] OP_SLT      = 8'd15;
  localparam logic [7:0] OP_SLTU     = 8'd16;
  localparam logic [7:0] OP_XOR      = 8'd17;
  localparam logic [7:0] OP_SRL      = 8'd18;
  localparam logic [7:0] OP_SRA      = 8'd19;
  localparam logic [7:0] OP_OR       = 8'd20;
  localparam logic [7:0] OP_AND      = 8'd21;
  localparam logic [7:0] OP_ADDW     = 8'd22;
  localparam logic [7:0] OP_SUBW     = 8'd23;
  localparam logic [7:0] OP_SLLW     = 8'd24;
  localparam logic [7:0] OP_SRLW     = 8'd25;
  localparam logic [7:0] OP_SRAW     = 8'd26;
  localparam logic [7:0] OP_AUIPC    = 8'd27;
  localparam logic [7:0] OP_LUI      = 8'd28;
  localparam logic [7:0] OP_SB       = 8'd29;
  localparam logic [7:0] OP_FSW      = 8'd33;
  localparam logic [7:0] OP_AMO_W    = 8'd35;
  localparam logic [7:0] OP_AMO_D    = 8'd46;
  localparam logic [7:0] OP_MUL      = 8'd57;
  localparam logic [7:0] OP_MULW     = 8'd65;
  localparam logic [7:0] OP_DIVW     = 8'd66;
  localparam logic [7:0] OP_FMADD    = 8'd70;
  localparam logic [7:0] OP_FADD     = 8'd78;
  localparam logic [7:0] OP_FSUB     = 8'd80;
  localparam logic [7:0] OP_FMUL     = 8'd82;
  localparam logic [7:0] OP_FDIV     = 8'd84;
  localparam logic [7:0] OP_FSQRT    = 8'd86;
  localparam logic [7:0] OP_FSGNJ    = 8'd88;
  localparam logic [7:0] OP_FMIN     = 8'd94;
  localparam logic [7:0] OP_FCVT_S_D = 8'd98;
  localparam logic [7:0] OP_FCVT_D_S = 8'd99;
  localparam logic [7:0] OP_FLE      = 8'd100;
  localparam logic [7:0] OP_FCLASS   = 8'd106;
  localparam logic [7:0] OP_FCVT_TO  = 8'd108;
  localparam logic [7:0] OP_FCVT_FR  = 8'd116;
  localparam logic [7:0] OP_FMV_X    = 8'd124;
  localparam logic [7:0] OP_FMV_F    = 8'd126;
  localparam logic [7:0] OP_BEQ      = 8'd128;
  localparam logic [7:0] OP_BLT      = 8'd130;
  localparam logic [7:0] OP_JALR     = 8'd134;
  localparam logic [7:0] OP_JAL      = 8'd135;
  localparam logic [7:0] OP_ECALL    = 8'd136;
  localparam logic [7:0] OP_EBREAK   = 8'd137;
  localparam logic [7:0] OP_SRET     = 8'd138;
  localparam logic [7:0] OP_WFI      = 8'd139;
  localparam logic [7:0] OP_MRET     = 8'd140;
  localparam logic [7:0] OP_SFENCE   = 8'd141;
  localparam logic [7:0] OP_CSRRW    = 8'd142;

endpackage
`default_nettype wire

// ===== rtl/rv64_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// rv64_instruction_decoder
// RV64IMAFD instruction decoder with registered input and result stages.
//
// Input channel in_valid/in_ready carries one 32-bit instruction word.
// Result channel out_valid/out_ready carries the operation number and four
// operand slots (kind and value each).
// The word is captured in an input register; the decode is one pass of
// combinational logic into the result register, which raises result valid;
// throughput is one instruction per cycle while the receiver does not stall,
// set by the two-entry register pipeline.
// Each stage advances when the stage after it is empty or being drained, so
// a stalled receiver holds the result and backs up the input stage; ready
// falls only when both stages are full.
// Reset empties both stages; no result is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none
module rv64_instruction_decoder
  import rv64dec_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [31:0] in_instruction_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [7:0]  out_operation_code,
  output logic             [2:0]  out_slot0_kind,
  output logic signed      [31:0] out_slot0_value,
  output logic             [2:0]  out_slot1_kind,
  output logic signed      [31:0] out_slot1_value,
  output logic             [2:0]  out_slot2_kind,
  output logic signed      [31:0] out_slot2_value,
  output logic             [2:0]  out_slot3_kind,
  output logic             [4:0]  out_slot3_value
);

  logic        v1_r, v2_r;
  logic [31:0] w_r;
  logic        adv2, adv1;

  logic [7:0]  op_nxt, op_r;
  kind_t       k0, k1, k2, k3;
  logic [31:0] s0, s1, s2;
  logic [4:0]  s3;
  kind_t       k0_r, k1_r, k2_r, k3_r;
  logic [31:0] s0_r, s1_r, s2_r;
  logic [4:0]  s3_r;

  assign adv2     = v1_r && (!v2_r || out_ready);
  assign in_ready = !v1_r || adv2;
  assign adv1     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (!v2_r || out_ready) v2_r <= v1_r;
    end
    if (adv1) w_r <= in_instruction_word;
    if (adv2) begin
      op_r <= op_nxt;
      k0_r <= k0; k1_r <= k1; k2_r <= k2; k3_r <= k3;
      s0_r <= s0; s1_r <= s1; s2_r <= s2; s3_r <= s3;
    end
  end

  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1, rs2, f5;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j;
  logic        dbit;
  logic [7:0]  aidx;
  logic [7:0]  rbase;

  always_comb begin
    opc   = w_r[6:0];
    rd    = w_r[11:7];
    f3    = w_r[14:12];
    rs1   = w_r[19:15];
    rs2   = w_r[24:20];
    f7    = w_r[31:25];
    f5    = w_r[31:27];
    dbit  = w_r[25];
    imm_i = {{20{w_r[31]}}, w_r[31:20]};
    imm_s = {{20{w_r[31]}}, w_r[31:25], w_r[11:7]};
    imm_b = {{20{w_r[31]}}, w_r[7], w_r[30:25], w_r[11:8], 1'b0};
    imm_j = {{12{w_r[31]}}, w_r[19:12], w_r[20], w_r[30:21], 1'b0};

    case (f3)
      3'd0:    rbase = OP_ADD;
      3'd1:    rbase = OP_SLL;
      3'd2:    rbase = OP_SLT;
      3'd3:    rbase = OP_SLTU;
      3'd4:    rbase = OP_XOR;
      3'd5:    rbase = OP_SRL;
      3'd6:    rbase = OP_OR;
      default: rbase = OP_AND;
    endcase

    case (f5)
      5'h02:   aidx = (rs2 == 5'd0) ? 8'd1 : 8'd0;
      5'h03:   aidx = 8'd2;
      5'h01:   aidx = 8'd3;
      5'h00:   aidx = 8'd4;
      5'h04:   aidx = 8'd5;
      5'h0c:   aidx = 8'd6;
      5'h08:   aidx = 8'd7;
      5'h10:   aidx = 8'd8;
      5'h14:   aidx = 8'd9;
      5'h18:   aidx = 8'd10;
      5'h1c:   aidx = 8'd11;
      default: aidx = 8'd0;
    endcase

    op_nxt = OP_INVALID;
    k0 = K_NONE; k1 = K_NONE; k2 = K_NONE; k3 = K_NONE;
    s0 = '0; s1 = '0; s2 = '0; s3 = '0;

    case (opc)
      OPC_LOAD: begin
        k0 = K_INT; s0 = {27'd0, rd}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_IMM; s2 = imm_i;
        if (f3 != 3'd7) op_nxt = OP_LB + {5'd0, f3};
      end
      OPC_LOAD_FP: begin
        k0 = K_FP; s0 = {27'd0, rd}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_IMM; s2 = imm_i;
        if (f3 == 3'd2 || f3 == 3'd3) op_nxt = OP_FLW + {7'd0, f3[0]};
      end
      OPC_MISC_MEM: begin
        k0 = K_IMM; s0 = {28'd0, w_r[27:24]};
        k1 = K_IMM; s1 = {28'd0, w_r[23:20]};
        if (w_r == W_FENCE_I) op_nxt = OP_FENCE_I;
        else if (f3 == 3'd0) op_nxt = OP_FENCE;
      end
      OPC_OP_IMM: begin
        k0 = K_INT; s0 = {27'd0, rd}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_IMM; s2 = imm_i;
        if (f3 == 3'd1) op_nxt = (f7[6:1] == 6'd0) ? OP_SLL : OP_INVALID;
        else if (f3 == 3'd5)
          op_nxt = (f7[6:1] == 6'd0) ? OP_SRL :
                   (f7[6:1] == 6'h10) ? OP_SRA : OP_INVALID;
        else op_nxt = rbase;
      end
      OPC_OP_IMM32: begin
        k0 = K_INT; s0 = {27'd0, rd}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_IMM; s2 = imm_i;
        if (f3 == 3'd0) op_nxt = OP_ADDW;
        else if (f3 == 3'd1 && f7 == 7'd0) op_nxt = OP_SLLW;
        else if (f3 == 3'd5 && f7 == 7'd0) op_nxt = OP_SRLW;
        else if (f3 == 3'd5 && f7 == 7'h20) op_nxt = OP_SRAW;
      end
      OPC_AUIPC, OPC_LUI: begin
        k0 = K_INT; s0 = {27'd0, rd}; k1 = K_IMM; s1 = {w_r[31:12], 12'd0};
        op_nxt = (opc == OPC_AUIPC) ? OP_AUIPC : OP_LUI;
      end
      OPC_STORE: begin
        k0 = K_INT; s0 = {27'd0, rs2}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_IMM; s2 = imm_s;
        if (!f3[2]) op_nxt = OP_SB + {5'd0, f3};
      end
      OPC_STORE_FP: begin
        k0 = K_FP; s0 = {27'd0, rs2}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_IMM; s2 = imm_s;
        if (f3 == 3'd2 || f3 == 3'd3) op_nxt = OP_FSW + {7'd0, f3[0]};
      end
      OPC_AMO: begin
        k0 = K_INT; s0 = {27'd0, rd}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_INT; s2 = {27'd0, rs2};
        if (aidx != 8'd0 && f3 == 3'd2) op_nxt = OP_AMO_W + aidx - 8'd1;
        else if (aidx != 8'd0 && f3 == 3'd3) op_nxt = OP_AMO_D + aidx - 8'd1;
      end
      OPC_OP: begin
        k0 = K_INT; s0 = {27'd0, rd}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_INT; s2 = {27'd0, rs2};
        if (f7 == 7'd1) op_nxt = OP_MUL + {5'd0, f3};
        else if (f7 == 7'd0) op_nxt = rbase;
        else if (f7 == 7'h20 && f3 == 3'd0) op_nxt = OP_SUB;
        else if (f7 == 7'h20 && f3 == 3'd5) op_nxt = OP_SRA;
      end
      OPC_OP32: begin
        k0 = K_INT; s0 = {27'd0, rd}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_INT; s2 = {27'd0, rs2};
        if (f7 == 7'd1) begin
          if (f3 == 3'd0) op_nxt = OP_MULW;
          else if (f3[2]) op_nxt = OP_DIVW + {6'd0, f3[1:0]};
        end else if (f7 == 7'd0) begin
          if (f3 == 3'd0) op_nxt = OP_ADDW;
          else if (f3 == 3'd1) op_nxt = OP_SLLW;
          else if (f3 == 3'd5) op_nxt = OP_SRLW;
        end else if (f7 == 7'h20) begin
          if (f3 == 3'd0) op_nxt = OP_SUBW;
          else if (f3 == 3'd5) op_nxt = OP_SRAW;
        end
      end
      OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD: begin
        k0 = K_FP; s0 = {27'd0, rd}; k1 = K_FP; s1 = {27'd0, rs1};
        k2 = K_FP; s2 = {27'd0, rs2}; k3 = K_FP; s3 = f5;
        if (!f7[1]) op_nxt = OP_FMADD + {5'd0, opc[3:2], dbit};
      end
      OPC_OP_FP: begin
        k0 = K_FP; s0 = {27'd0, rd}; k1 = K_FP; s1 = {27'd0, rs1};
        k2 = K_FP; s2 = {27'd0, rs2};
        if (!f7[1]) begin
          case (f5)
            5'h00: op_nxt = OP_FADD + {7'd0, dbit};
            5'h01: op_nxt = OP_FSUB + {7'd0, dbit};
            5'h02: op_nxt = OP_FMUL + {7'd0, dbit};
            5'h03: op_nxt = OP_FDIV + {7'd0, dbit};
            5'h0b: if (rs2 == 5'd0) op_nxt = OP_FSQRT + {7'd0, dbit};
            5'h04: if (f3 < 3'd3) op_nxt = OP_FSGNJ + {5'd0, f3[1:0], dbit};
            5'h05: if (f3 < 3'd2) op_nxt = OP_FMIN + {6'd0, f3[0], dbit};
            5'h08: begin
              if (!dbit && rs2 == 5'd1) op_nxt = OP_FCVT_S_D;
              else if (dbit && rs2 == 5'd0) op_nxt = OP_FCVT_D_S;
            end
            5'h14: if (f3 < 3'd3) begin
              k0 = K_INT; op_nxt = OP_FLE + {5'd0, f3[1:0], dbit};
            end
            5'h18: if (rs2 < 5'd4) begin
              k0 = K_INT; op_nxt = OP_FCVT_TO + {5'd0, rs2[1:0], dbit};
            end
            5'h1a: if (rs2 < 5'd4) begin
              k1 = K_INT; op_nxt = OP_FCVT_FR + {5'd0, rs2[1:0], dbit};
            end
            5'h1c: if (rs2 == 5'd0 && f3 < 3'd2) begin
              k0 = K_INT;
              op_nxt = (f3 == 3'd0) ? OP_FMV_X + {7'd0, dbit} : OP_FCLASS + {7'd0, dbit};
            end
            5'h1e: if (rs2 == 5'd0 && f3 == 3'd0) begin
              k1 = K_INT; op_nxt = OP_FMV_F + {7'd0, dbit};
            end
            default: op_nxt = OP_INVALID;
          endcase
        end
      end
      OPC_BRANCH: begin
        k0 = K_INT; s0 = {27'd0, rs1}; k1 = K_INT; s1 = {27'd0, rs2};
        k2 = K_IMM; s2 = imm_b;
        if (f3 < 3'd2) op_nxt = OP_BEQ + {7'd0, f3[0]};
        else if (f3[2]) op_nxt = OP_BLT + {6'd0, f3[1:0]};
      end
      OPC_JALR: begin
        k0 = K_INT; s0 = {27'd0, rd}; k1 = K_INT; s1 = {27'd0, rs1};
        k2 = K_IMM; s2 = imm_i;
        if (f3 == 3'd0) op_nxt = OP_JALR;
      end
      OPC_JAL: begin
        k0 = K_INT; s0 = {27'd0, rd}; k1 = K_IMM; s1 = imm_j;
        op_nxt = OP_JAL;
      end
      OPC_SYSTEM: begin
        if (w_r == W_ECALL) op_nxt = OP_ECALL;
        else if (w_r == W_EBREAK) op_nxt = OP_EBREAK;
        else if (w_r == W_SRET) op_nxt = OP_SRET;
        else if (w_r == W_WFI) op_nxt = OP_WFI;
        else if (w_r == W_MRET) op_nxt = OP_MRET;
        else if (rd == 5'd0 && f3 == 3'd0 && f7 == 7'h09) begin
          k0 = K_INT; s0 = {27'd0, rs1}; k1 = K_INT; s1 = {27'd0, rs2};
          op_nxt = OP_SFENCE;
        end else begin
          k0 = K_INT; s0 = {27'd0, rd}; k1 = K_CSR; s1 = {20'd0, w_r[31:20]};
          k2 = f3[2] ? K_IMM : K_INT; s2 = {27'd0, rs1};
          if (f3[1:0] != 2'd0) op_nxt = OP_CSRRW + {6'd0, f3[1:0]} - 8'd1;
        end
      end
      default: op_nxt = OP_INVALID;
    endcase
  end

  assign out_valid          = v2_r;
  assign out_operation_code = op_r;
  assign out_slot0_kind     = k0_r;
  assign out_slot0_value    = s0_r;
  assign out_slot1_kind     = k1_r;
  assign out_slot1_value    = s1_r;
  assign out_slot2_kind     = k2_r;
  assign out_slot2_value    = s2_r;
  assign out_slot3_kind     = k3_r;
  assign out_slot3_value    = s3_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !out_ready |=> v2_r && $stable(op_r) && $stable(s0_r))
    else $error("result changed while stalled");
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && !out_ready)
    else $error("input stalled with room");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    adv1 |=> v1_r)
    else $error("accepted word lost");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && k3_r == K_NONE |-> s3_r == 5'd0)
    else $error("empty slot carries a value");

endmodule
`default_nettype wire

// ===== tb/rv64_instruction_decoder_check.sv =====
// ----------------------------------------------------------------------------
// rv64_instruction_decoder_check
// Watches both channels of the decoder, decodes each accepted word on its
// own and compares every result field with the oldest pending decode.
// ----------------------------------------------------------------------------
`default_nettype none
module rv64_instruction_decoder_check
  import rv64dec_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic        [31:0] in_instruction_word,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic        [7:0]  out_operation_code,
  input  wire logic        [2:0]  out_slot0_kind,
  input  wire logic signed [31:0] out_slot0_value,
  input  wire logic        [2:0]  out_slot1_kind,
  input  wire logic signed [31:0] out_slot1_value,
  input  wire logic        [2:0]  out_slot2_kind,
  input  wire logic signed [31:0] out_slot2_value,
  input  wire logic        [2:0]  out_slot3_kind,
  input  wire logic        [4:0]  out_slot3_value,
  output int                      fail_count,
  output int                      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  op;
    kind_t [3:0] kind;
    logic [2:0][31:0] val;
    logic [4:0]  rs3;
  } decode_t;

  decode_t decoded_q[$];

  function automatic logic [31:0] sx(logic [31:0] v, int bits);
    logic [31:0] m;
    m = (32'd1 << bits) - 1;
    v = v & m;
    if (v[bits-1]) v = v | ~m;
    return v;
  endfunction

  function automatic logic [7:0] reg_base(logic [2:0] f3);
    case (f3)
      3'd0: return OP_ADD;
      3'd1: return OP_SLL;
      3'd2: return OP_SLT;
      3'd3: return OP_SLTU;
      3'd4: return OP_XOR;
      3'd5: return OP_SRL;
      3'd6: return OP_OR;
      default: return OP_AND;
    endcase
  endfunction

  function automatic logic [7:0] amo_offset(logic [4:0] f5, logic [4:0] rs2);
    case (f5)
      5'h02: return rs2 == 0 ? 8'd1 : 8'd0;
      5'h03: return 8'd2;
      5'h01: return 8'd3;
      5'h00: return 8'd4;
      5'h04: return 8'd5;
      5'h0c: return 8'd6;
      5'h08: return 8'd7;
      5'h10: return 8'd8;
      5'h14: return 8'd9;
      5'h18: return 8'd10;
      5'h1c: return 8'd11;
      default: return 8'd0;
    endcase
  endfunction

  function automatic void put(inout decode_t r, input int s, input kind_t k,
                              input logic [31:0] v);
    r.kind[s] = k;
    if (s < 3) r.val[s] = v;
    else r.rs3 = v[4:0];
  endfunction

  function automatic decode_t decode_word(logic [31:0] w);
    decode_t r;
    logic [6:0] opc, f7;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [31:0] ii, is;
    logic [7:0] d, a;
    opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15];
    rs2 = w[24:20]; f7 = w[31:25];
    ii = sx(w >> 20, 12);
    is = sx({w[31:25], w[11:7]}, 12);
    d = {7'd0, f7[0]};
    r = '0;
    for (int i = 0; i < 4; i++) r.kind[i] = K_NONE;
    r.op = OP_INVALID;
    case (opc)
      OPC_LOAD: begin
        put(r, 0, K_INT, rd); put(r, 1, K_INT, rs1); put(r, 2, K_IMM, ii);
        if (f3 < 7) r.op = OP_LB + f3;
      end
      OPC_LOAD_FP: begin
        put(r, 0, K_FP, rd); put(r, 1, K_INT, rs1); put(r, 2, K_IMM, ii);
        if (f3 == 2 || f3 == 3) r.op = OP_FLW + f3 - 2;
      end
      OPC_MISC_MEM: begin
        put(r, 0, K_IMM, w[27:24]); put(r, 1, K_IMM, w[23:20]);
        if (w == W_FENCE_I) r.op = OP_FENCE_I;
        else if (f3 == 0) r.op = OP_FENCE;
      end
      OPC_OP_IMM: begin
        put(r, 0, K_INT, rd); put(r, 1, K_INT, rs1); put(r, 2, K_IMM, ii);
        if (f3 == 1) r.op = f7[6:1] == 0 ? OP_SLL : OP_INVALID;
        else if (f3 == 5)
          r.op = f7[6:1] == 0 ? OP_SRL : f7[6:1] == 6'h10 ? OP_SRA : OP_INVALID;
        else r.op = reg_base(f3);
      end
      OPC_OP_IMM32: begin
        put(r, 0, K_INT, rd); put(r, 1, K_INT, rs1); put(r, 2, K_IMM, ii);
        if (f3 == 0) r.op = OP_ADDW;
        else if (f3 == 1 && f7 == 0) r.op = OP_SLLW;
        else if (f3 == 5 && f7 == 0) r.op = OP_SRLW;
        else if (f3 == 5 && f7 == 7'h20) r.op = OP_SRAW;
      end
      OPC_AUIPC, OPC_LUI: begin
        put(r, 0, K_INT, rd); put(r, 1, K_IMM, w & 32'hfffff000);
        r.op = opc == OPC_AUIPC ? OP_AUIPC : OP_LUI;
      end
      OPC_STORE: begin
        put(r, 0, K_INT, rs2); put(r, 1, K_INT, rs1); put(r, 2, K_IMM, is);
        if (f3 < 4) r.op = OP_SB + f3;
      end
      OPC_STORE_FP: begin
        put(r, 0, K_FP, rs2); put(r, 1, K_INT, rs1); put(r, 2, K_IMM, is);
        if (f3 == 2 || f3 == 3) r.op = OP_FSW + f3 - 2;
      end
      OPC_AMO: begin
        a = amo_offset(f7[6:2], rs2);
        put(r, 0, K_INT, rd); put(r, 1, K_INT, rs1); put(r, 2, K_INT, rs2);
        if (a != 0 && f3 == 2) r.op = OP_AMO_W + a - 1;
        else if (a != 0 && f3 == 3) r.op = OP_AMO_D + a - 1;
      end
      OPC_OP: begin
        put(r, 0, K_INT, rd); put(r, 1, K_INT, rs1); put(r, 2, K_INT, rs2);
        if (f7 == 1) r.op = OP_MUL + f3;
        else if (f7 == 0) r.op = reg_base(f3);
        else if (f7 == 7'h20 && f3 == 0) r.op = OP_SUB;
        else if (f7 == 7'h20 && f3 == 5) r.op = OP_SRA;
      end
      OPC_OP32: begin
        put(r, 0, K_INT, rd); put(r, 1, K_INT, rs1); put(r, 2, K_INT, rs2);
        if (f7 == 1) begin
          if (f3 == 0) r.op = OP_MULW;
          else if (f3 >= 4) r.op = OP_DIVW + f3 - 4;
        end else if (f7 == 0) begin
          if (f3 == 0) r.op = OP_ADDW;
          else if (f3 == 1) r.op = OP_SLLW;
          else if (f3 == 5) r.op = OP_SRLW;
        end else if (f7 == 7'h20) begin
          if (f3 == 0) r.op = OP_SUBW;
          else if (f3 == 5) r.op = OP_SRAW;
        end
      end
      OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD: begin
        put(r, 0, K_FP, rd); put(r, 1, K_FP, rs1); put(r, 2, K_FP, rs2);
        put(r, 3, K_FP, w[31:27]);
        if (f7[1:0] < 2) r.op = OP_FMADD + 2 * opc[3:2] + d;
      end
      OPC_OP_FP: begin
        put(r, 0, K_FP, rd); put(r, 1, K_FP, rs1); put(r, 2, K_FP, rs2);
        if (f7[1:0] < 2) begin
          case (f7[6:2])
            5'h00: r.op = OP_FADD + d;
            5'h01: r.op = OP_FSUB + d;
            5'h02: r.op = OP_FMUL + d;
            5'h03: r.op = OP_FDIV + d;
            5'h0b: if (rs2 == 0) r.op = OP_FSQRT + d;
            5'h04: if (f3 < 3) r.op = OP_FSGNJ + 2 * f3 + d;
            5'h05: if (f3 < 2) r.op = OP_FMIN + 2 * f3 + d;
            5'h08: begin
              if (d == 0 && rs2 == 1) r.op = OP_FCVT_S_D;
              else if (d == 1 && rs2 == 0) r.op = OP_FCVT_D_S;
            end
            5'h14: if (f3 < 3) begin
              r.kind[0] = K_INT; r.op = OP_FLE + 2 * f3 + d;
            end
            5'h18: if (rs2 < 4) begin
              r.kind[0] = K_INT; r.op = OP_FCVT_TO + 2 * rs2 + d;
            end
            5'h1a: if (rs2 < 4) begin
              r.kind[1] = K_INT; r.op = OP_FCVT_FR + 2 * rs2 + d;
            end
            5'h1c: if (rs2 == 0 && f3 < 2) begin
              r.kind[0] = K_INT; r.op = f3 == 0 ? OP_FMV_X + d : OP_FCLASS + d;
            end
            5'h1e: if (rs2 == 0 && f3 == 0) begin
              r.kind[1] = K_INT; r.op = OP_FMV_F + d;
            end
            default: ;
          endcase
        end
      end
      OPC_BRANCH: begin
        put(r, 0, K_INT, rs1); put(r, 1, K_INT, rs2);
        put(r, 2, K_IMM, sx({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13));
        if (f3 < 2) r.op = OP_BEQ + f3;
        else if (f3 >= 4) r.op = OP_BLT + f3 - 4;
      end
      OPC_JALR: begin
        put(r, 0, K_INT, rd); put(r, 1, K_INT, rs1); put(r, 2, K_IMM, ii);
        if (f3 == 0) r.op = OP_JALR;
      end
      OPC_JAL: begin
        put(r, 0, K_INT, rd);
        put(r, 1, K_IMM, sx({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21));
        r.op = OP_JAL;
      end
      OPC_SYSTEM: begin
        if (w == W_ECALL) r.op = OP_ECALL;
        else if (w == W_EBREAK) r.op = OP_EBREAK;
        else if (w == W_SRET) r.op = OP_SRET;
        else if (w == W_WFI) r.op = OP_WFI;
        else if (w == W_MRET) r.op = OP_MRET;
        else if (rd == 0 && f3 == 0 && f7 == 7'h09) begin
          put(r, 0, K_INT, rs1); put(r, 1, K_INT, rs2); r.op = OP_SFENCE;
        end else begin
          put(r, 0, K_INT, rd); put(r, 1, K_CSR, w[31:20]);
          put(r, 2, f3[2] ? K_IMM : K_INT, rs1);
          if (f3[1:0] != 0) r.op = OP_CSRRW + f3[1:0] - 1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_count = decoded_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    decode_t e;
    if (rst_n) begin
      if (in_valid && in_ready) decoded_q.push_back(decode_word(in_instruction_word));
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result op %h", $time, out_operation_code);
          fail_count++;
        end else begin
          e = decoded_q.pop_front();
          cmp("operation_code", e.op, out_operation_code);
          cmp("slot0_kind", e.kind[0], out_slot0_kind);
          cmp("slot0_value", e.val[0], out_slot0_value);
          cmp("slot1_kind", e.kind[1], out_slot1_kind);
          cmp("slot1_value", e.val[1], out_slot1_value);
          cmp("slot2_kind", e.kind[2], out_slot2_kind);
          cmp("slot2_value", e.val[2], out_slot2_value);
          cmp("slot3_kind", e.kind[3], out_slot3_kind);
          cmp("slot3_value", e.rs3, out_slot3_value);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/rv64_instruction_decoder_test.sv =====
// ----------------------------------------------------------------------------
// rv64_instruction_decoder_test
// Feeds the decoder directed words for some encoding groups and every special word,
// then mostly well-formed random instructions with random fields plus raw
// noise, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module rv64_instruction_decoder_test;
  import rv64dec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic [31:0] in_instruction_word = '0;
  logic in_ready, out_valid;
  logic [7:0] out_operation_code;
  logic [2:0] out_slot0_kind, out_slot1_kind, out_slot2_kind, out_slot3_kind;
  logic signed [31:0] out_slot0_value, out_slot1_value, out_slot2_value;
  logic [4:0] out_slot3_value;
  int fail_count, pending_count, cycle_count = 0;

  rv64_instruction_decoder i_dut (.*);
  rv64_instruction_decoder_check i_check (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("rv64_instruction_decoder_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    case ((cycle_count / 300) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 3) != 0;
      default: out_ready <= (cycle_count % 7) < 3;
    endcase
  end

  logic [6:0] major_list[21] = '{OPC_LOAD, OPC_LOAD_FP, OPC_MISC_MEM, OPC_OP_IMM,
    OPC_AUIPC, OPC_OP_IMM32, OPC_STORE, OPC_STORE_FP, OPC_AMO, OPC_OP, OPC_LUI,
    OPC_OP32, OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD, OPC_OP_FP,
    OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM};

  int burst_left = 0;

  task automatic send_word(logic [31:0] w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_instruction_word <= w;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [6:0] f7;
    int pick;
    w = $urandom;
    pick = $urandom_range(0, 9);
    if (pick == 0) return w;
    w[6:0] = major_list[$urandom_range(0, 20)];
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      case ($urandom_range(0, 5))
        0: f7 = 7'h00;
        1: f7 = 7'h01;
        2: f7 = 7'h20;
        3: f7 = 7'h09;
        4: f7 = {5'($urandom_range(0, 31)), 2'b0} | 7'($urandom_range(0, 1));
        default: f7 = {5'($urandom_range(0, 31)), 2'b0};
      endcase
      w[31:25] = f7;
    end
    if (pick >= 6) w[24:20] = 5'($urandom_range(0, 4));
    if (pick == 9 && w[6:0] == OPC_SYSTEM) w[11:7] = 5'd0;
    return w;
  endfunction

  initial begin
    logic [31:0] directed[$] = '{32'h00000000, 32'hffffffff, W_FENCE_I, 32'h0ff0000f,
      32'h0000200f, W_ECALL, W_EBREAK, W_SRET, W_WFI, W_MRET, 32'h12b00073,
      32'hfff2a0f3, 32'h8001e173, 32'h34079073, 32'h40005013, 32'h02005013,
      32'h4000503b, 32'h0012f2af, 32'h1802b2af, 32'hfe0f8fe3, 32'h800000ef,
      32'h7ffff0ef, 32'hfff00067, 32'h0000106f, 32'hf0000ac3};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_word(directed[i]);
    repeat (1450) send_word(random_word());
    if (burst_left != 0) in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) $display("rv64_instruction_decoder_test OK");
    else $display("rv64_instruction_decoder_test NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
